// ===== sv/tpms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tpms_pkg;

    // Field widths of the item channels and the configuration port
    localparam int IN_POS_W   = 32;
    localparam int DRIVE_W    = 32;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int PROP_W     = 24;
    localparam int DERIV_W    = 32;
    localparam int HOLD_W     = 16;
    localparam int TOL_W      = 16;

    // Default width of the target registers
    localparam int POS_WIDTH_DEF = 32;

    // Register reset values
    localparam logic [PROP_W-1:0]  PROP_GAIN_RST  = PROP_W'(51200);
    localparam logic [DERIV_W-1:0] DERIV_GAIN_RST = DERIV_W'(12800000);
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = HOLD_W'(1000);
    localparam logic [TOL_W-1:0]   ARRIVE_TOL_RST = TOL_W'(17);

    // Slide steps per tick and the fixed set points, 2^-24 rad
    localparam logic signed [IN_POS_W-1:0] STEP_A   = -32'sd4194;
    localparam logic signed [IN_POS_W-1:0] STEP_B   = -32'sd6711;
    localparam logic signed [IN_POS_W-1:0] STEP_C   = -32'sd1678;
    localparam logic signed [IN_POS_W-1:0] GRIP_SET = 32'sd83886;
    localparam logic signed [IN_POS_W-1:0] TURN_SET = 32'sd13176795;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 4'd0,
        PH_RAMP      = 4'd1,
        PH_HOLD_A    = 4'd2,
        PH_SET_GRIP  = 4'd3,
        PH_HOLD_B    = 4'd4,
        PH_SET_TURN  = 4'd5,
        PH_HOLD_C    = 4'd6,
        PH_ZERO_TURN = 4'd7,
        PH_RET_GRIP  = 4'd8,
        PH_RET_SLIDE = 4'd9
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_HOLD_TICKS   = 3'd2,
        REG_ARRIVE_TOL   = 3'd3,
        REG_HOME_SLIDE   = 3'd4,
        REG_HOME_GRIPPER = 3'd5,
        REG_HOME_TURN    = 3'd6
    } t_reg_idx;

endpackage
`default_nettype wire

// ===== sv/tpms_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tpms_in_if import tpms_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       start_a;
    logic                       start_b;
    logic                       start_c;
    logic signed [IN_POS_W-1:0] pos_slide;
    logic signed [IN_POS_W-1:0] pos_gripper;
    logic signed [IN_POS_W-1:0] pos_turn;

    modport source (
        output valid, start_a, start_b, start_c, pos_slide, pos_gripper, pos_turn,
        input  ready
    );
    modport sink (
        input  valid, start_a, start_b, start_c, pos_slide, pos_gripper, pos_turn,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/tpms_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tpms_out_if import tpms_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_slide;
    logic signed [DRIVE_W-1:0] drive_gripper;
    logic signed [DRIVE_W-1:0] drive_turn;
    logic                      busy_res;
    logic [PHASE_W-1:0]        phase;

    modport source (
        output valid, drive_slide, drive_gripper, drive_turn, busy_res, phase,
        input  ready
    );
    modport sink (
        input  valid, drive_slide, drive_gripper, drive_turn, busy_res, phase,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/three_axis_pd_motion_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Three-axis PD motion sequencer. Each input item is one control tick carrying
// three start buttons and the measured slide, gripper and turn positions; each
// tick yields exactly one result item with three saturated Q15.16 torques, the
// busy flag and the phase code after the tick. A new item is taken every
// cycle unless a stalled result blocks the input register; an accepted item
// passes through the input register, one pass of sequencer update, PD
// multiplies and saturation, and the result register, which it leaves once
// the result side is ready. A stalled result holds in the result
// register while the input register still accepts one more item. Write the
// configuration registers only while no tick is in flight; writing a home
// position while idle also loads that joint's target and previous position.
// No clearing pass is needed after reset.
module three_axis_pd_motion_sequencer_unit import tpms_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tpms_in_if.sink                    i_in,
    tpms_out_if.source                 o_out
);

    // Error width covers target minus position without overflow
    localparam int ERR_W = ((POS_WIDTH > IN_POS_W) ? POS_WIDTH : IN_POS_W) + 1;
    localparam int DE_W  = IN_POS_W + 1;
    localparam int PP_W  = ERR_W + PROP_W + 1;
    localparam int PD_W  = DE_W + DERIV_W + 1;
    localparam int SUM_W = ((PP_W > PD_W) ? PP_W : PD_W) + 1;

    localparam logic signed [ERR_W-1:0] POS_MAX =
        {{(ERR_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] POS_MIN =
        {{(ERR_W-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] DRV_MAX =
        {{(SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] DRV_MIN =
        {{(SUM_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

    function automatic logic signed [ERR_W-1:0] ext_in(input logic signed [IN_POS_W-1:0] v);
        return {{(ERR_W-IN_POS_W){v[IN_POS_W-1]}}, v};
    endfunction

    function automatic logic signed [ERR_W-1:0] ext_tgt(input logic signed [POS_WIDTH-1:0] v);
        return {{(ERR_W-POS_WIDTH){v[POS_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [ERR_W-1:0] v);
        logic signed [ERR_W-1:0] c;
        begin
            if (v > POS_MAX) begin
                c = POS_MAX;
            end else if (v < POS_MIN) begin
                c = POS_MIN;
            end else begin
                c = v;
            end
            return c[POS_WIDTH-1:0];
        end
    endfunction

    function automatic logic arrived(
        input logic signed [POS_WIDTH-1:0] tgt,
        input logic signed [IN_POS_W-1:0]  pos,
        input logic [TOL_W-1:0]            tol
    );
        logic signed [ERR_W-1:0] d;
        logic [ERR_W-1:0]        m;
        begin
            d = ext_tgt(tgt) - ext_in(pos);
            m = d[ERR_W-1] ? ERR_W'(-d) : ERR_W'(d);
            return m < {{(ERR_W-TOL_W){1'b0}}, tol};
        end
    endfunction

    // Configuration registers
    logic [PROP_W-1:0]          r_prop_gain,  n_prop_gain;
    logic [DERIV_W-1:0]         r_deriv_gain, n_deriv_gain;
    logic [HOLD_W-1:0]          r_hold_ticks, n_hold_ticks;
    logic [TOL_W-1:0]           r_arrive_tol, n_arrive_tol;
    logic signed [IN_POS_W-1:0] r_home_slide, n_home_slide;
    logic signed [IN_POS_W-1:0] r_home_grip,  n_home_grip;
    logic signed [IN_POS_W-1:0] r_home_turn,  n_home_turn;

    // Sequencer state
    t_phase                      r_phase,      n_phase;
    logic [HOLD_W-1:0]           r_tick,       n_tick;
    logic signed [IN_POS_W-1:0]  r_slide_step, n_slide_step;
    logic signed [POS_WIDTH-1:0] r_tgt_slide,  n_tgt_slide;
    logic signed [POS_WIDTH-1:0] r_tgt_grip,   n_tgt_grip;
    logic signed [POS_WIDTH-1:0] r_tgt_turn,   n_tgt_turn;
    logic signed [IN_POS_W-1:0]  r_last [3];
    logic signed [IN_POS_W-1:0]  n_last [3];

    // Input register
    logic                       r_in_valid;
    logic                       r_start_a, r_start_b, r_start_c;
    logic signed [IN_POS_W-1:0] r_pos [3];

    // Result register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive [3];
    logic                      r_busy;
    t_phase                    r_out_phase;

    // Item-updated values, valid while the input register holds an item
    t_phase                      u_phase;
    logic [HOLD_W-1:0]           u_tick;
    logic signed [IN_POS_W-1:0]  u_slide_step;
    logic signed [POS_WIDTH-1:0] u_tgt [3];
    logic signed [DRIVE_W-1:0]   u_drive [3];

    logic adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    // Sequencer: button start, phase step, tick counter and target updates
    always_comb begin
        t_phase ph;
        t_phase nxt;
        logic   due;
        ph              = r_phase;
        u_tick          = r_tick;
        u_slide_step    = r_slide_step;
        u_tgt[0]        = r_tgt_slide;
        u_tgt[1]        = r_tgt_grip;
        u_tgt[2]        = r_tgt_turn;
        if (ph == PH_IDLE) begin
            if (r_start_a) begin
                u_slide_step = STEP_A;
                ph           = PH_RAMP;
            end else if (r_start_b) begin
                u_slide_step = STEP_B;
                ph           = PH_RAMP;
            end else if (r_start_c) begin
                u_slide_step = STEP_C;
                ph           = PH_RAMP;
            end
            u_tick = '0;
        end
        due = (u_tick >= r_hold_ticks);
        nxt = ph;
        unique case (ph)
            PH_RAMP: begin
                u_tgt[0] = sat_pos(ext_tgt(u_tgt[0]) + ext_in(u_slide_step));
                if (due) nxt = PH_HOLD_A;
            end
            PH_HOLD_A: begin
                if (due) nxt = PH_SET_GRIP;
            end
            PH_SET_GRIP: begin
                u_tgt[1] = sat_pos(ext_in(GRIP_SET));
                if (due) nxt = PH_HOLD_B;
            end
            PH_HOLD_B: begin
                if (due) nxt = PH_SET_TURN;
            end
            PH_SET_TURN: begin
                u_tgt[2] = sat_pos(ext_in(TURN_SET));
                if (due) nxt = PH_HOLD_C;
            end
            PH_HOLD_C: begin
                if (due) nxt = PH_RET_GRIP;
            end
            PH_RET_GRIP: begin
                u_tgt[1] = sat_pos(ext_in(r_home_grip));
                if (arrived(u_tgt[1], r_pos[1], r_arrive_tol)) nxt = PH_ZERO_TURN;
            end
            PH_ZERO_TURN: begin
                u_tgt[2] = '0;
                if (due) nxt = PH_RET_SLIDE;
            end
            PH_RET_SLIDE: begin
                u_tgt[0] = sat_pos(ext_in(r_home_slide));
                if (arrived(u_tgt[0], r_pos[0], r_arrive_tol)) nxt = PH_IDLE;
            end
            default: begin
            end
        endcase
        if (nxt != ph) u_tick = '0;
        // Count active ticks, saturating
        if (nxt != PH_IDLE && u_tick != {HOLD_W{1'b1}}) u_tick = u_tick + 1'b1;
        u_phase = nxt;
    end

    // PD loops, one per axis
    for (genvar j = 0; j < 3; j++) begin : g_axis
        logic signed [ERR_W-1:0] err_p;
        logic signed [DE_W-1:0]  err_d;
        logic signed [PP_W-1:0]  prod_p;
        logic signed [PD_W-1:0]  prod_d;
        logic signed [PP_W-1:0]  sh_p;
        logic signed [PD_W-1:0]  sh_d;
        logic signed [SUM_W-1:0] sum;

        assign err_p  = ext_tgt(u_tgt[j]) - ext_in(r_pos[j]);
        assign err_d  = {r_last[j][IN_POS_W-1], r_last[j]} - {r_pos[j][IN_POS_W-1], r_pos[j]};
        assign prod_p = err_p * $signed({1'b0, r_prop_gain});
        assign prod_d = err_d * $signed({1'b0, r_deriv_gain});
        // Drop 16 fraction bits, rounding toward minus infinity
        assign sh_p   = prod_p >>> 16;
        assign sh_d   = prod_d >>> 16;
        assign sum    = {{(SUM_W-PP_W){sh_p[PP_W-1]}}, sh_p}
                      + {{(SUM_W-PD_W){sh_d[PD_W-1]}}, sh_d};

        always_comb begin
            if (sum > DRV_MAX) begin
                u_drive[j] = DRV_MAX[DRIVE_W-1:0];
            end else if (sum < DRV_MIN) begin
                u_drive[j] = DRV_MIN[DRIVE_W-1:0];
            end else begin
                u_drive[j] = sum[DRIVE_W-1:0];
            end
        end
    end

    // Next state: the item update, else a configuration write
    always_comb begin
        n_prop_gain  = r_prop_gain;
        n_deriv_gain = r_deriv_gain;
        n_hold_ticks = r_hold_ticks;
        n_arrive_tol = r_arrive_tol;
        n_home_slide = r_home_slide;
        n_home_grip  = r_home_grip;
        n_home_turn  = r_home_turn;
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_slide_step = r_slide_step;
        n_tgt_slide  = r_tgt_slide;
        n_tgt_grip   = r_tgt_grip;
        n_tgt_turn   = r_tgt_turn;
        n_last       = r_last;
        if (adv) begin
            n_phase      = u_phase;
            n_tick       = u_tick;
            n_slide_step = u_slide_step;
            n_tgt_slide  = u_tgt[0];
            n_tgt_grip   = u_tgt[1];
            n_tgt_turn   = u_tgt[2];
            n_last       = r_pos;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PROP_GAIN:  n_prop_gain  = i_cfg_data[PROP_W-1:0];
                REG_DERIV_GAIN: n_deriv_gain = i_cfg_data[DERIV_W-1:0];
                REG_HOLD_TICKS: n_hold_ticks = i_cfg_data[HOLD_W-1:0];
                REG_ARRIVE_TOL: n_arrive_tol = i_cfg_data[TOL_W-1:0];
                REG_HOME_SLIDE: begin
                    n_home_slide = i_cfg_data[IN_POS_W-1:0];
                    if (r_phase == PH_IDLE) begin
                        n_tgt_slide = sat_pos(ext_in(i_cfg_data[IN_POS_W-1:0]));
                        n_last[0]   = i_cfg_data[IN_POS_W-1:0];
                    end
                end
                REG_HOME_GRIPPER: begin
                    n_home_grip = i_cfg_data[IN_POS_W-1:0];
                    if (r_phase == PH_IDLE) begin
                        n_tgt_grip = sat_pos(ext_in(i_cfg_data[IN_POS_W-1:0]));
                        n_last[1]  = i_cfg_data[IN_POS_W-1:0];
                    end
                end
                REG_HOME_TURN: begin
                    n_home_turn = i_cfg_data[IN_POS_W-1:0];
                    if (r_phase == PH_IDLE) begin
                        n_tgt_turn = sat_pos(ext_in(i_cfg_data[IN_POS_W-1:0]));
                        n_last[2]  = i_cfg_data[IN_POS_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
            r_arrive_tol <= ARRIVE_TOL_RST;
            r_home_slide <= '0;
            r_home_grip  <= '0;
            r_home_turn  <= '0;
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_slide_step <= '0;
            r_tgt_slide  <= '0;
            r_tgt_grip   <= '0;
            r_tgt_turn   <= '0;
            r_last[0]    <= '0;
            r_last[1]    <= '0;
            r_last[2]    <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prop_gain  <= n_prop_gain;
            r_deriv_gain <= n_deriv_gain;
            r_hold_ticks <= n_hold_ticks;
            r_arrive_tol <= n_arrive_tol;
            r_home_slide <= n_home_slide;
            r_home_grip  <= n_home_grip;
            r_home_turn  <= n_home_turn;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_slide_step <= n_slide_step;
            r_tgt_slide  <= n_tgt_slide;
            r_tgt_grip   <= n_tgt_grip;
            r_tgt_turn   <= n_tgt_turn;
            r_last       <= n_last;
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_start_a <= i_in.start_a;
            r_start_b <= i_in.start_b;
            r_start_c <= i_in.start_c;
            r_pos[0]  <= i_in.pos_slide;
            r_pos[1]  <= i_in.pos_gripper;
            r_pos[2]  <= i_in.pos_turn;
        end
        if (adv) begin
            r_drive     <= u_drive;
            r_busy      <= (u_phase != PH_IDLE);
            r_out_phase <= u_phase;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.drive_slide   = r_drive[0];
    assign o_out.drive_gripper = r_drive[1];
    assign o_out.drive_turn    = r_drive[2];
    assign o_out.busy_res      = r_busy;
    assign o_out.phase         = r_out_phase;

endmodule
`default_nettype wire
